[hdl/mp2_pkg.sv]
// shared types and constants for the 2x2 stride-2 max pooling block
// no dependencies; imported by every module under hdl

package mp2_pkg;

  localparam int DEF_MAX_ROW_WIDTH = 1024;
  localparam int DEF_PIXEL_BITS    = 16;

  // configuration port
  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 2;

  localparam int ROW_WIDTH_RESET  = 4;
  localparam int FRAME_ROWS_RESET = 4;
  localparam int FRAME_ROWS_MIN   = 2;
  localparam int FRAME_ROWS_MAX   = 1024;
  localparam int ROW_WIDTH_MIN    = 2;
  localparam int ROW_BITS         = 10;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROW_WIDTH  = 2'd0,
    REG_FRAME_ROWS = 2'd1
  } cfg_reg_t;

  // classification of one horizontal pixel pair
  typedef struct packed {
    logic emit;          // odd row: combine with line store and send out
    logic end_of_row;
    logic end_of_frame;
  } pair_ctl_t;

endpackage

[hdl/mp2_front.sv]
// front end: configuration registers, column/row counters, pair classification
// depends on mp2_pkg

module mp2_front #(
  parameter int MAX_ROW_WIDTH = mp2_pkg::DEF_MAX_ROW_WIDTH,
  parameter int PIXEL_BITS    = mp2_pkg::DEF_PIXEL_BITS,
  parameter int IDX_BITS      = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [mp2_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mp2_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                               pix_valid,
  output logic                               pix_ready,
  input  logic signed [PIXEL_BITS-1:0]       pixel,
  input  logic                               q_ready,
  output logic                               q_push,
  output mp2_pkg::pair_ctl_t                 q_ctl,
  output logic [IDX_BITS-1:0]                q_idx,
  output logic signed [PIXEL_BITS-1:0]       q_left,
  output logic signed [PIXEL_BITS-1:0]       q_right
);
  import mp2_pkg::*;

  localparam int LINE_DEPTH = MAX_ROW_WIDTH / 2;
  localparam int COL_BITS   = $clog2(MAX_ROW_WIDTH + 1);

  function automatic logic [COL_BITS-1:0] clamp_width(input logic [CFG_BITS-1:0] v);
    logic [COL_BITS-1:0] res;
    if (32'(v) < 32'(ROW_WIDTH_MIN)) res = COL_BITS'(ROW_WIDTH_MIN);
    else if (32'(v) > 32'(MAX_ROW_WIDTH)) res = COL_BITS'(MAX_ROW_WIDTH);
    else res = COL_BITS'(v);
    return res;
  endfunction

  function automatic logic [CFG_BITS-1:0] clamp_rows(input logic [CFG_BITS-1:0] v);
    logic [CFG_BITS-1:0] res;
    if (32'(v) < 32'(FRAME_ROWS_MIN)) res = CFG_BITS'(FRAME_ROWS_MIN);
    else if (32'(v) > 32'(FRAME_ROWS_MAX)) res = CFG_BITS'(FRAME_ROWS_MAX);
    else res = v;
    return res;
  endfunction

  logic [COL_BITS-1:0]        width_eff;
  logic [CFG_BITS-1:0]        rows_eff;
  logic [COL_BITS-1:0]        column_count;
  logic [ROW_BITS-1:0]        row_count;
  logic signed [PIXEL_BITS-1:0] left_pixel;

  logic                       accept;
  logic [COL_BITS-2:0]        pair_idx;
  logic                       idx_ok;
  logic                       last_col;
  logic                       last_row;

  // a register write takes the cycle, so no pixel transfer can coincide with it
  assign pix_ready = q_ready & ~cfg_valid;
  assign accept    = pix_valid & pix_ready;
  assign pair_idx  = column_count[COL_BITS-1:1];
  assign idx_ok    = COL_BITS'(pair_idx) < COL_BITS'(LINE_DEPTH);
  assign last_col  = (COL_BITS + 1)'(column_count) + (COL_BITS + 1)'(1)
                     >= (COL_BITS + 1)'(width_eff);
  assign last_row  = CFG_BITS'(row_count) + CFG_BITS'(1) >= rows_eff;

  always_comb begin
    q_push             = accept & column_count[0] & idx_ok;
    q_idx              = pair_idx[IDX_BITS-1:0];
    q_left             = left_pixel;
    q_right            = pixel;
    q_ctl.emit         = row_count[0];
    q_ctl.end_of_row   = COL_BITS'(pair_idx) + COL_BITS'(1) >= (width_eff >> 1);
    q_ctl.end_of_frame = q_ctl.end_of_row &&
                         (CFG_BITS'(row_count[ROW_BITS-1:1]) + CFG_BITS'(1)
                          >= (rows_eff >> 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff    <= clamp_width(CFG_BITS'(ROW_WIDTH_RESET));
      rows_eff     <= clamp_rows(CFG_BITS'(FRAME_ROWS_RESET));
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (cfg_valid) begin
      // a write to the row width or frame rows register restarts the frame
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH: begin
          width_eff    <= clamp_width(cfg_data);
          column_count <= '0;
          row_count    <= '0;
        end
        REG_FRAME_ROWS: begin
          rows_eff     <= clamp_rows(cfg_data);
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (!column_count[0]) begin
        left_pixel <= pixel;
      end
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + COL_BITS'(1);
      end
    end
  end

endmodule

[hdl/mp2_queue.sv]
// short fifo that decouples pair classification from the line store back end
// depends on mp2_pkg for its depth

module mp2_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 not_full,
  input  logic                 pop,
  output logic                 not_empty,
  output logic [DATA_BITS-1:0] head_data
);
  import mp2_pkg::*;

  logic [DATA_BITS-1:0]      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;

  assign not_full  = fill != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (QUEUE_PTR_BITS + 1)'(1);
        2'b01:   fill <= fill - (QUEUE_PTR_BITS + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/mp2_back.sv]
// back end: pair maximum, line store of even-row maxima, final compare, output register
// depends on mp2_pkg

module mp2_back #(
  parameter int MAX_ROW_WIDTH = mp2_pkg::DEF_MAX_ROW_WIDTH,
  parameter int PIXEL_BITS    = mp2_pkg::DEF_PIXEL_BITS,
  parameter int IDX_BITS      = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  mp2_pkg::pair_ctl_t           q_ctl,
  input  logic [IDX_BITS-1:0]          q_idx,
  input  logic signed [PIXEL_BITS-1:0] q_left,
  input  logic signed [PIXEL_BITS-1:0] q_right,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PIXEL_BITS-1:0] out_value,
  output logic                         out_eor,
  output logic                         out_eof
);
  import mp2_pkg::*;

  localparam int LINE_DEPTH = MAX_ROW_WIDTH / 2;

  logic signed [PIXEL_BITS-1:0] pair_max_line [LINE_DEPTH];

  logic signed [PIXEL_BITS-1:0] pair_max;
  logic                         adv_out;
  logic                         load_s1;

  // stage 1: line store read data and the pair maximum of the odd row
  logic                         s1_valid;
  logic signed [PIXEL_BITS-1:0] s1_above;
  logic signed [PIXEL_BITS-1:0] s1_pair;
  logic                         s1_eor;
  logic                         s1_eof;

  assign pair_max = (q_right > q_left) ? q_right : q_left;
  assign adv_out  = !out_valid || out_ready;
  assign load_s1  = !s1_valid || adv_out;
  // even-row pairs only write the store, so they never wait on the output
  assign q_pop    = q_valid && (!q_ctl.emit || load_s1);

  always_ff @(posedge clk) begin
    if (q_pop && !q_ctl.emit) begin
      pair_max_line[q_idx] <= pair_max;
    end
    if (q_pop && q_ctl.emit) begin
      s1_above <= pair_max_line[q_idx];
      s1_pair  <= pair_max;
      s1_eor   <= q_ctl.end_of_row;
      s1_eof   <= q_ctl.end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      out_value <= (s1_above > s1_pair) ? s1_above : s1_pair;
      out_eor   <= s1_eor;
      out_eof   <= s1_eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_s1) s1_valid  <= q_pop && q_ctl.emit;
      if (adv_out) out_valid <= s1_valid;
    end
  end

endmodule

[hdl/max_pool_2x2_stride2.sv]
// top level of the 2x2 stride-2 max pooling block
// depends on mp2_pkg, mp2_front, mp2_queue, mp2_back
//
//  channel  | direction | transfer                 | payload
//  ---------+-----------+--------------------------+-------------------------------------
//  s_axis   | in        | s_tvalid & s_tready      | tdata: pixel
//  m_axis   | out       | m_tvalid & m_tready      | tdata: pooled_value, tuser: end_of_row,
//           |           |                          | tlast: end_of_frame
//  cfg      | in        | cfg_valid & cfg_ready    | cfg_index, cfg_data
//
// one pixel is taken per clock while s_tready is high; from its lower-right pixel
// transfer the 2x2 result passes through the queue slot, then the line store read
// register, then the output register. the line store takes one access per cycle, one per pixel pair.
// reset is synchronous and clears counters, queue and valid flags; the line store
// is not cleared. a stalled output fills the queue and then holds s_tready low;
// a register write also holds s_tready low for its cycle.

module max_pool_2x2_stride2 #(
  parameter int MAX_ROW_WIDTH = mp2_pkg::DEF_MAX_ROW_WIDTH,
  parameter int PIXEL_BITS    = mp2_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((PIXEL_BITS + 7) / 8)*8-1:0] s_tdata,   // pixel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((PIXEL_BITS + 7) / 8)*8-1:0] m_tdata,   // pooled_value
  output logic [0:0]                          m_tuser,   // end_of_row
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mp2_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mp2_pkg::CFG_BITS-1:0]        cfg_data
);
  import mp2_pkg::*;

  localparam int LINE_DEPTH = MAX_ROW_WIDTH / 2;
  localparam int IDX_BITS   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CTL_BITS   = $bits(pair_ctl_t);
  localparam int Q_BITS     = CTL_BITS + IDX_BITS + 2 * PIXEL_BITS;

  logic                         f_push;
  pair_ctl_t                    f_ctl;
  logic [IDX_BITS-1:0]          f_idx;
  logic signed [PIXEL_BITS-1:0] f_left;
  logic signed [PIXEL_BITS-1:0] f_right;

  logic                         q_not_full;
  logic                         q_not_empty;
  logic                         q_pop;
  logic [Q_BITS-1:0]            q_head;
  pair_ctl_t                    b_ctl;
  logic [IDX_BITS-1:0]          b_idx;
  logic signed [PIXEL_BITS-1:0] b_left;
  logic signed [PIXEL_BITS-1:0] b_right;

  logic signed [PIXEL_BITS-1:0] pooled_value;
  logic                         end_of_row;

  assign cfg_ready = 1'b1;

  mp2_front #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS),
    .IDX_BITS      (IDX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pixel     (s_tdata[PIXEL_BITS-1:0]),
    .q_ready   (q_not_full),
    .q_push    (f_push),
    .q_ctl     (f_ctl),
    .q_idx     (f_idx),
    .q_left    (f_left),
    .q_right   (f_right)
  );

  mp2_queue #(
    .DATA_BITS (Q_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_ctl, f_idx, f_left, f_right}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  assign {b_ctl, b_idx, b_left, b_right} = q_head;

  mp2_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS),
    .IDX_BITS      (IDX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_ctl     (b_ctl),
    .q_idx     (b_idx),
    .q_left    (b_left),
    .q_right   (b_right),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (pooled_value),
    .out_eor   (end_of_row),
    .out_eof   (m_tlast)
  );

  always_comb begin
    m_tdata                 = '0;
    m_tdata[PIXEL_BITS-1:0] = pooled_value;
    m_tuser[0]              = end_of_row;
  end

endmodule
